FILE: rtl/core/rbdb_pkg.sv
// Shared types and constants for the RGB565 box darken/blend unit.
// No dependencies; every other file of the block imports this package.
package rbdb_pkg;

    // Cap on the coordinate span that the limit registers set.
    localparam int C_MAX_COORD = 2048;

    // x / 255 equals (x * 0x8081) >> 23 for every 16-bit x.
    localparam logic [15:0] C_RECIP_255 = 16'h8081;
    localparam int C_RECIP_SHIFT = 23;

    // Register map of the configuration port, in hardware index order.
    typedef enum logic [2:0] {
        REG_BOX_LEFT,
        REG_BOX_TOP,
        REG_BOX_RIGHT,
        REG_BOX_BOTTOM,
        REG_LIMIT_RIGHT,
        REG_LIMIT_BOTTOM,
        REG_FILL_COLOR,
        REG_BLEND_LEVEL
    } t_reg_idx;

    typedef logic [31:0][7:0] t_a8_tab;

    // Level to 8-bit alpha, level * 255 / 31, built at elaboration.
    function automatic t_a8_tab f_build_a8();
        t_a8_tab tab;
        for (int i = 0; i < 32; i++) begin
            tab[i] = 8'((i * 255) / 31);
        end
        return tab;
    endfunction

    localparam t_a8_tab C_A8_TAB = f_build_a8();

    typedef struct packed {
        logic [10:0] pixel_x;
        logic [10:0] pixel_y;
        logic [15:0] pixel_in;
    } t_in;

    typedef struct packed {
        logic [15:0] pixel_out;
        logic        was_inside;
    } t_out;

    // Settings derived from the configuration registers.
    typedef struct packed {
        logic signed [12:0] left;
        logic signed [12:0] top;
        logic signed [12:0] right;
        logic signed [12:0] bottom;
        logic               dark;
        logic [2:0][5:0]    fill;
        logic [7:0]         a8;
        logic [7:0]         inv_a8;
        logic [4:0]         rev;
    } t_cfg;

endpackage

FILE: rtl/core/rbdb_cfg.sv
// Configuration registers and the clipped box / blend factors derived from them.
// Depends on rbdb_pkg.
module rbdb_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    output rbdb_pkg::t_cfg      o_cfg
);
    import rbdb_pkg::*;

    logic [11:0] r_box_left;
    logic [11:0] r_box_top;
    logic [11:0] r_box_right;
    logic [11:0] r_box_bottom;
    logic [11:0] r_limit_right;
    logic [11:0] r_limit_bottom;
    logic [15:0] r_fill_color;
    logic [4:0]  r_blend_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_left     <= '0;
            r_box_top      <= '0;
            r_box_right    <= '0;
            r_box_bottom   <= '0;
            r_limit_right  <= '0;
            r_limit_bottom <= '0;
            r_fill_color   <= '0;
            r_blend_level  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BOX_LEFT:     r_box_left     <= i_cfg_data[11:0];
                REG_BOX_TOP:      r_box_top      <= i_cfg_data[11:0];
                REG_BOX_RIGHT:    r_box_right    <= i_cfg_data[11:0];
                REG_BOX_BOTTOM:   r_box_bottom   <= i_cfg_data[11:0];
                REG_LIMIT_RIGHT:  r_limit_right  <= i_cfg_data[11:0];
                REG_LIMIT_BOTTOM: r_limit_bottom <= i_cfg_data[11:0];
                REG_FILL_COLOR:   r_fill_color   <= i_cfg_data;
                REG_BLEND_LEVEL:  r_blend_level  <= i_cfg_data[4:0];
                default:          r_blend_level  <= r_blend_level;
            endcase
        end
    end

    logic [11:0]        lim_r;
    logic [11:0]        lim_b;
    logic signed [12:0] box_r;
    logic signed [12:0] box_b;
    logic signed [12:0] cap_r;
    logic signed [12:0] cap_b;

    always_comb begin
        lim_r = (int'(r_limit_right) > C_MAX_COORD) ? 12'(C_MAX_COORD) : r_limit_right;
        lim_b = (int'(r_limit_bottom) > C_MAX_COORD) ? 12'(C_MAX_COORD) : r_limit_bottom;
        cap_r = signed'({1'b0, lim_r});
        cap_b = signed'({1'b0, lim_b});
        box_r = signed'({r_box_right[11], r_box_right});
        box_b = signed'({r_box_bottom[11], r_box_bottom});

        // Negative left and top edges clamp to the first column and row.
        o_cfg.left   = r_box_left[11] ? '0 : signed'({1'b0, r_box_left});
        o_cfg.top    = r_box_top[11] ? '0 : signed'({1'b0, r_box_top});
        o_cfg.right  = (box_r > cap_r) ? cap_r : box_r;
        o_cfg.bottom = (box_b > cap_b) ? cap_b : box_b;

        o_cfg.dark    = (r_fill_color == 16'd0);
        o_cfg.fill[0] = {1'b0, r_fill_color[15:11]};
        o_cfg.fill[1] = r_fill_color[10:5];
        o_cfg.fill[2] = {1'b0, r_fill_color[4:0]};
        o_cfg.a8      = C_A8_TAB[r_blend_level];
        o_cfg.inv_a8  = 8'd255 - C_A8_TAB[r_blend_level];
        o_cfg.rev     = 5'd31 - r_blend_level;
    end

endmodule

FILE: rtl/core/rbdb_pipe.sv
// Four-stage datapath: box test/products, sum, divide by 255 or shift, pack.
// Depends on rbdb_pkg; settings come from rbdb_cfg.
module rbdb_pipe (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rbdb_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    output logic            o_stall,
    input  rbdb_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output rbdb_pkg::t_out  o_data
);
    import rbdb_pkg::*;

    // Stage enables: a stage loads when it is empty or the next one moves.
    logic [3:0] en;
    logic       r1_vld, r2_vld, r3_vld, r4_vld;

    always_comb begin
        en[3] = !r4_vld || !i_stall;
        en[2] = !r3_vld || en[3];
        en[1] = !r2_vld || en[2];
        en[0] = !r1_vld || en[1];
    end

    assign o_stall = !en[0];

    // Stage 1: box test and channel products.
    logic signed [12:0] px;
    logic signed [12:0] py;
    logic               in_box;
    logic [2:0][5:0]    dst;
    logic [2:0][13:0]   n1_pa;
    logic [2:0][13:0]   n1_pb;

    always_comb begin
        px = signed'({2'b00, i_data.pixel_x});
        py = signed'({2'b00, i_data.pixel_y});
        in_box = (px >= i_cfg.left) && (px < i_cfg.right) &&
                 (py >= i_cfg.top) && (py < i_cfg.bottom);
        dst[0] = {1'b0, i_data.pixel_in[15:11]};
        dst[1] = i_data.pixel_in[10:5];
        dst[2] = {1'b0, i_data.pixel_in[4:0]};
        for (int c = 0; c < 3; c++) begin
            if (i_cfg.dark) begin
                n1_pa[c] = 14'(dst[c]) * 14'(i_cfg.rev);
                n1_pb[c] = '0;
            end else begin
                n1_pa[c] = 14'(i_cfg.fill[c]) * 14'(i_cfg.a8);
                n1_pb[c] = 14'(dst[c]) * 14'(i_cfg.inv_a8);
            end
        end
    end

    logic [15:0]      r1_pix;
    logic             r1_inside;
    logic             r1_dark;
    logic [2:0][13:0] r1_pa;
    logic [2:0][13:0] r1_pb;

    // Stage 2: channel sums.
    logic [15:0]      r2_pix;
    logic             r2_inside;
    logic             r2_dark;
    logic [2:0][13:0] r2_sum;

    // Stage 3: quotient by 255, or the darkening shift.
    logic [15:0]      r3_pix;
    logic             r3_inside;
    logic [2:0][5:0]  r3_q;
    logic [2:0][29:0] prod;
    logic [2:0][5:0]  n3_q;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            prod[c] = 30'(r2_sum[c]) * 30'(C_RECIP_255);
            n3_q[c] = r2_dark ? r2_sum[c][10:5] : prod[c][C_RECIP_SHIFT +: 6];
        end
    end

    // Stage 4: output register.
    logic [15:0] r4_pix;
    logic        r4_inside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            if (en[0]) r1_vld <= i_valid;
            if (en[1]) r2_vld <= r1_vld;
            if (en[2]) r3_vld <= r2_vld;
            if (en[3]) r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_pix    <= i_data.pixel_in;
            r1_inside <= in_box;
            r1_dark   <= i_cfg.dark;
            r1_pa     <= n1_pa;
            r1_pb     <= n1_pb;
        end
        if (en[1]) begin
            r2_pix    <= r1_pix;
            r2_inside <= r1_inside;
            r2_dark   <= r1_dark;
            for (int c = 0; c < 3; c++) begin
                r2_sum[c] <= r1_pa[c] + r1_pb[c];
            end
        end
        if (en[2]) begin
            r3_pix    <= r2_pix;
            r3_inside <= r2_inside;
            r3_q      <= n3_q;
        end
        if (en[3]) begin
            r4_inside <= r3_inside;
            r4_pix    <= r3_inside ? {r3_q[0][4:0], r3_q[1], r3_q[2][4:0]} : r3_pix;
        end
    end

    assign o_valid           = r4_vld;
    assign o_data.pixel_out  = r4_pix;
    assign o_data.was_inside = r4_inside;

    // The block only holds off its source while a finished beat is stuck.
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r4_vld |-> !o_stall)
        else $error("input stalled while the output stage is empty");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r1_vld)
        else $error("accepted beat did not reach the first stage");

    a_mid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_vld && !en[2] |=> r2_vld && $stable(r2_sum) && $stable(r2_pix))
        else $error("held beat in the sum stage changed or vanished");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_vld && r4_vld && i_stall |=> r3_vld && $stable(r3_q))
        else $error("beat behind a stalled output was lost");

endmodule

FILE: rtl/core/rgb565_box_darken_or_blend_unit.sv
// Top level of the RGB565 box darken/blend unit.
// Depends on rbdb_pkg, rbdb_cfg and rbdb_pipe.
//
// This unit takes a stream of RGB565 framebuffer pixels, each with its column
// and row, and returns every pixel exactly once and in order. A pixel that lies
// inside the programmed box, after the box is clipped to start at zero and to end
// at the limit registers (which are themselves capped at 2048), is either darkened
// or blended toward the fill color, and its was_inside flag is set. A fill color
// of zero selects darkening, where each channel becomes channel*(31-level)>>5;
// any other fill color blends each channel as (fill*a8 + dest*(255-a8))/255 with
// a8 = level*255/31. Pixels outside the box, and all pixels when the box is empty,
// pass through unchanged. A beat is accepted at a rising edge with i_valid high and
// o_stall low, and a result leaves at an edge with o_valid high and i_stall low.
// Stages: products and box test, channel sums, the reciprocal multiply that divides
// by 255, and the output register. One pixel is accepted every cycle while the
// output is taken; each stage loads whenever it is empty or its successor moves,
// so a stalled output stops only the beats behind it and empty stages still fill.
// The user must write configuration through i_cfg_we, i_cfg_idx and i_cfg_data
// only while no beat is in flight (not enforced); all registers reset to zero.
module rgb565_box_darken_or_blend_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_idx,
    input  logic [15:0]     i_cfg_data,
    input  logic            i_valid,
    output logic            o_stall,
    input  rbdb_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output rbdb_pkg::t_out  o_data
);
    import rbdb_pkg::*;

    // Clipped box and blend factors, held steady between configuration writes.
    t_cfg cfg;

    rbdb_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // The pixel datapath with its per-stage valid bits and stall chain.
    rbdb_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule
